### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication between a trigger and a consequence in the next cycle.
`define ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/rau_pkg.sv
package rau_pkg;

  localparam int WordWidthDef = 32;

  localparam logic [2:0] OP_MAKE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]   op;
    logic [31:0]  a_num;
    logic [31:0]  a_den;
    logic [31:0]  b_num;
    logic [31:0]  b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_equal;
    logic [1:0]         status;
  } rau_res_t;

endpackage

### rtl/core/rational_arith_unit.sv
// Rational arithmetic unit: make, add, subtract, multiply, divide, equal.
// A request on req_i is transferred at a rising edge with start high and
// busy low. The unit then stays busy until the result is ready; valid_o is
// high for exactly one cycle with the result on res_o, and that cycle ends
// the result transfer. The receiver cannot hold the result off; busy is
// already low in that same cycle, so a new request may be started at once.
// Each operand and the final value are reduced by one shared datapath:
// a binary gcd that removes one bit per cycle, followed by two restoring
// divisions, of the numerator and then the denominator, by that gcd. Make
// needs one reduction, equal two, and the arithmetic operations three plus
// two or three products on the shared WORD_WIDTH multiplier.
// Zero denominators and results that do not fit give 0/1 with a status code.
// Reset returns the unit to idle with no result pending.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int WORD_WIDTH = WordWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rau_req_t req_i,
  output logic     valid_o,
  output rau_res_t res_o
);

  localparam int W  = WORD_WIDTH;
  localparam int MW = 2 * WORD_WIDTH;
  localparam int CW = $clog2(MW);
  localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_GCD_INIT = 4'd1;
  localparam logic [3:0] S_GCD      = 4'd2;
  localparam logic [3:0] S_DIVN     = 4'd3;
  localparam logic [3:0] S_DIVD     = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_MUL1     = 4'd6;
  localparam logic [3:0] S_MUL2     = 4'd7;
  localparam logic [3:0] S_MUL3     = 4'd8;
  localparam logic [3:0] S_COMB     = 4'd9;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  logic [3:0]    state_q, state_d;
  logic          valid_q, valid_d;
  logic [1:0]    phase_q, phase_d;
  logic [2:0]    op_q, op_d;
  logic [W-1:0]  bnum_raw_q, bnum_raw_d, bden_raw_q, bden_raw_d;
  logic          an_neg_q, an_neg_d, bn_neg_q, bn_neg_d;
  logic [W-1:0]  an_mag_q, an_mag_d, ad_q, ad_d, bn_mag_q, bn_mag_d, bd_q, bd_d;
  logic          rn_neg_q, rn_neg_d, rd_neg_q, rd_neg_d;
  logic [MW-1:0] rn_q, rn_d, rd_q, rd_d;
  logic [MW-1:0] x_q, x_d, y_q, y_d, god_q, god_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic [MW-1:0] quo_q, quo_d, rem_q, rem_d, nq_q, nq_d;
  logic          zden_q, zden_d;
  logic [MW-1:0] p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  rau_res_t      res_q, res_d;

  // Operand magnitudes from the low WORD_WIDTH bits of the raw fields.
  logic [W-1:0]  in_an, in_ad, in_bn, in_bd;
  logic [W-1:0]  raw_an, raw_ad, raw_bn, raw_bd;
  assign raw_an = req_i.a_num[W-1:0];
  assign raw_ad = req_i.a_den[W-1:0];
  assign raw_bn = bnum_raw_q;
  assign raw_bd = bden_raw_q;
  assign in_an  = raw_an[W-1] ? (~raw_an + W'(1)) : raw_an;
  assign in_ad  = raw_ad[W-1] ? (~raw_ad + W'(1)) : raw_ad;
  assign in_bn  = raw_bn[W-1] ? (~raw_bn + W'(1)) : raw_bn;
  assign in_bd  = raw_bd[W-1] ? (~raw_bd + W'(1)) : raw_bd;

  // Shared multiplier.
  logic [W-1:0]  mul_x, mul_y;
  logic [MW-1:0] prod;
  assign prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  // Shared divider step.
  logic [MW:0]   rem_sh;
  logic          div_ge;
  logic [MW:0]   rem_sub;
  assign rem_sh  = {rem_q, quo_q[MW-1]};
  assign div_ge  = rem_sh >= {1'b0, god_q};
  assign rem_sub = rem_sh - {1'b0, god_q};

  // Outcome of one reduction.
  logic          red_neg, red_ovf, red_nneg;
  logic [1:0]    red_status;
  logic [W-1:0]  red_mag, red_den, num_w;
  rau_res_t      red_res;
  assign red_neg = (nq_q != '0) && (rn_neg_q != rd_neg_q);
  assign red_ovf = (quo_q[MW-1:W-1] != '0) ||
                   ((nq_q[MW-1:W-1] != '0) && !(red_neg && nq_q == LIM));
  always_comb begin
    if (zden_q) begin
      red_status = ST_ZERO_DEN;
    end else if (red_ovf) begin
      red_status = ST_OVERFLOW;
    end else begin
      red_status = ST_OK;
    end
  end
  assign red_nneg = (red_status == ST_OK) && red_neg;
  assign red_mag  = (red_status == ST_OK) ? nq_q[W-1:0] : '0;
  assign red_den  = (red_status == ST_OK) ? quo_q[W-1:0] : W'(1);
  assign num_w    = red_nneg ? (~red_mag + W'(1)) : red_mag;
  always_comb begin
    red_res          = '0;
    red_res.res_num  = 32'($signed(num_w));
    red_res.res_den  = 31'(red_den[W-2:0]);
    red_res.is_equal = 1'b0;
    red_res.status   = red_status;
  end

  // Signed sum of the two cross products for add and subtract.
  logic          t2_neg;
  logic [MW-1:0] sum_mag;
  logic          sum_neg;
  assign t2_neg = bn_neg_q ^ (op_q == OP_SUB);
  always_comb begin
    if (an_neg_q == t2_neg) begin
      sum_mag = p1_q + p2_q;
      sum_neg = an_neg_q;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
      sum_neg = an_neg_q;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = t2_neg;
    end
  end

  always_comb begin
    state_d    = state_q;
    valid_d    = 1'b0;
    phase_d    = phase_q;
    op_d       = op_q;
    bnum_raw_d = bnum_raw_q;
    bden_raw_d = bden_raw_q;
    an_neg_d   = an_neg_q;
    an_mag_d   = an_mag_q;
    ad_d       = ad_q;
    bn_neg_d   = bn_neg_q;
    bn_mag_d   = bn_mag_q;
    bd_d       = bd_q;
    rn_neg_d   = rn_neg_q;
    rd_neg_d   = rd_neg_q;
    rn_d       = rn_q;
    rd_d       = rd_q;
    x_d        = x_q;
    y_d        = y_q;
    god_d      = god_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    nq_d       = nq_q;
    zden_d     = zden_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    p3_d       = p3_q;
    res_d      = res_q;
    mul_x      = an_mag_q;
    mul_y      = bd_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = (req_i.op > OP_EQ) ? OP_MAKE : req_i.op;
          bnum_raw_d = req_i.b_num[W-1:0];
          bden_raw_d = req_i.b_den[W-1:0];
          rn_neg_d   = raw_an[W-1];
          rd_neg_d   = raw_ad[W-1];
          rn_d       = MW'(in_an);
          rd_d       = MW'(in_ad);
          phase_d    = PH_A;
          state_d    = S_GCD_INIT;
        end
      end
      S_GCD_INIT: begin
        if (rd_q == '0) begin
          zden_d  = 1'b1;
          state_d = S_CHECK;
        end else begin
          zden_d  = 1'b0;
          x_d     = rn_q;
          y_d     = rd_q;
          k_d     = '0;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (x_q == '0 || y_q == '0) begin
          // The remaining operand is the odd part of the gcd.
          god_d   = (x_q == '0) ? y_q : x_q;
          quo_d   = rn_q >> k_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIVN;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = (x_q - y_q) >> 1;
        end else begin
          y_d = (y_q - x_q) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        rem_d = div_ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
        quo_d = {quo_q[MW-2:0], div_ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MW - 1)) begin
          if (state_q == S_DIVN) begin
            nq_d    = {quo_q[MW-2:0], div_ge};
            quo_d   = rd_q >> k_q;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIVD;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        unique case (phase_q)
          PH_A: begin
            an_neg_d = red_nneg;
            an_mag_d = red_mag;
            ad_d     = red_den;
            if (red_status != ST_OK || op_q == OP_MAKE) begin
              res_d   = red_res;
              valid_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              rn_neg_d = raw_bn[W-1];
              rd_neg_d = raw_bd[W-1];
              rn_d     = MW'(in_bn);
              rd_d     = MW'(in_bd);
              phase_d  = PH_B;
              state_d  = S_GCD_INIT;
            end
          end
          PH_B: begin
            bn_neg_d = red_nneg;
            bn_mag_d = red_mag;
            bd_d     = red_den;
            if (red_status != ST_OK) begin
              res_d   = red_res;
              valid_d = 1'b1;
              state_d = S_IDLE;
            end else if (op_q == OP_EQ) begin
              // The equal operation reports the fixed value 0/1 beside the flag.
              res_d          = '0;
              res_d.res_den  = 31'd1;
              res_d.status   = ST_OK;
              res_d.is_equal = (an_neg_q == red_nneg) && (an_mag_q == red_mag) &&
                               (ad_q == red_den);
              valid_d        = 1'b1;
              state_d        = S_IDLE;
            end else begin
              state_d = S_MUL1;
            end
          end
          default: begin
            res_d   = red_res;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL1: begin
        mul_x   = an_mag_q;
        mul_y   = (op_q == OP_MUL) ? bn_mag_q : bd_q;
        p1_d    = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        mul_x   = ad_q;
        mul_y   = (op_q == OP_MUL) ? bd_q : bn_mag_q;
        p2_d    = prod;
        state_d = (op_q == OP_ADD || op_q == OP_SUB) ? S_MUL3 : S_COMB;
      end
      S_MUL3: begin
        mul_x   = ad_q;
        mul_y   = bd_q;
        p3_d    = prod;
        state_d = S_COMB;
      end
      S_COMB: begin
        phase_d = PH_R;
        state_d = S_GCD_INIT;
        if (op_q == OP_MUL) begin
          rn_neg_d = an_neg_q ^ bn_neg_q;
          rn_d     = p1_q;
          rd_neg_d = 1'b0;
          rd_d     = p2_q;
        end else if (op_q == OP_DIV) begin
          rn_neg_d = an_neg_q;
          rn_d     = p1_q;
          rd_neg_d = bn_neg_q;
          rd_d     = p2_q;
        end else begin
          rn_neg_d = sum_neg;
          rn_d     = sum_mag;
          rd_neg_d = 1'b0;
          rd_d     = p3_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      phase_q <= PH_A;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    bnum_raw_q <= bnum_raw_d;
    bden_raw_q <= bden_raw_d;
    an_neg_q   <= an_neg_d;
    an_mag_q   <= an_mag_d;
    ad_q       <= ad_d;
    bn_neg_q   <= bn_neg_d;
    bn_mag_q   <= bn_mag_d;
    bd_q       <= bd_d;
    rn_neg_q   <= rn_neg_d;
    rd_neg_q   <= rd_neg_d;
    rn_q       <= rn_d;
    rd_q       <= rd_d;
    x_q        <= x_d;
    y_q        <= y_d;
    god_q      <= god_d;
    k_q        <= k_d;
    cnt_q      <= cnt_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    nq_q       <= nq_d;
    zden_q     <= zden_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    p3_q       <= p3_d;
    res_q      <= res_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Set when the result fields hold the fixed value 0/1.
  logic res_null;
  assign res_null = (res_o.res_num == 32'sd0) && (res_o.res_den == 31'd1);

`include "assert_macros.svh"

  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `ASSERT_ALWAYS(a_valid_idle, !valid_o || !busy)
  `ASSERT_ALWAYS(a_err_zero, !valid_o || res_o.status == ST_OK || (res_null && !res_o.is_equal))
  `ASSERT_ALWAYS(a_eq_fields, !valid_o || !res_o.is_equal || res_null)

endmodule
